@@ hdl/padded_integer_field_formatter_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the padded integer field formatter
// Shared concurrent check forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PADDED_INTEGER_FIELD_FORMATTER_CORE_MACROS_SVH
`define PADDED_INTEGER_FIELD_FORMATTER_CORE_MACROS_SVH

// same-cycle implication
`define PIFC_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("pifc: same-cycle check failed");

// next-cycle implication
`define PIFC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("pifc: next-cycle check failed");

`endif

@@ hdl/pifc_pkg.sv @@
// ----------------------------------------------------------------------------
// pifc_pkg
// Types, sizes, character codes and helpers of the integer field formatter.
// ----------------------------------------------------------------------------
package pifc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_WIDTH  = 64;

  // fixed field widths
  localparam int FWIDTH_W = 7;
  localparam int PREC_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int SUM_W    = 8;

  // conversion: 4 magnitude bits per cycle
  localparam int ITERS      = (VALUE_BITS + 3) / 4;
  localparam int ITER_W     = $clog2(ITERS);
  localparam int MAG_W      = ITERS * 4;
  localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCD_W      = DEC_DIGITS * 4;
  localparam int DD_W       = BCD_W + MAG_W;
  localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);
  localparam int DIG_SLOTS  = 1 << DIG_IDX_W;

  localparam logic FUNC_DEC = 1'b0;
  localparam logic FUNC_HEX = 1'b1;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_HEX_BASE = 8'h57;  // 'a' - 10

  typedef struct packed {
    logic                  func;
    logic [VALUE_BITS-1:0] value;
    logic [FWIDTH_W-1:0]   field_width;
    logic [PREC_W-1:0]     precision;
  } pifc_in_t;

  typedef struct packed {
    logic [7:0]         character;
    logic               last;
    logic [COUNT_W-1:0] char_count;
  } pifc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } pifc_state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic size;
    logic emit;
  } pifc_cmd_t;

  typedef struct packed {
    logic is_hex;
    logic emit_last;
  } pifc_sts_t;

  // one double-dabble bit: add 3 to every BCD digit >= 5, then shift left
  function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] x);
    logic [DD_W-1:0] y;
    logic [3:0]      d;
    y = x;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      d = y[MAG_W + 4*i +: 4];
      if (d >= 4'd5) begin
        y[MAG_W + 4*i +: 4] = d + 4'd3;
      end
    end
    return y << 1;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return CH_HEX_BASE + {4'd0, d};
  endfunction

endpackage

@@ hdl/pifc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pifc_ctrl
// Sequencer: load, digit conversion, field sizing, character emission.
// ----------------------------------------------------------------------------
module pifc_ctrl
  import pifc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  pifc_sts_t sts,
  output logic      busy,
  output pifc_cmd_t cmd
);

`include "padded_integer_field_formatter_core_macros.svh"

  pifc_state_t       state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              iter_done;

  assign iter_done = (iter_r == ITER_W'(ITERS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_IDLE: begin
        iter_nxt = '0;
        if (start) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        iter_nxt = iter_r + 1'b1;
        if (sts.is_hex || iter_done) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV: cmd.conv = 1'b1;
      ST_SIZE: cmd.size = 1'b1;
      ST_EMIT: cmd.emit = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  `PIFC_ASSERT_IMPLY(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.conv, cmd.size, cmd.emit}))
  `PIFC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && cmd.conv)
  `PIFC_ASSERT_NEXT(a_conv_bound, clk, rst_n, cmd.conv && iter_done, !cmd.conv)

endmodule

@@ hdl/pifc_dp.sv @@
// ----------------------------------------------------------------------------
// pifc_dp
// Operand registers, BCD converter, field layout and character output.
// ----------------------------------------------------------------------------
module pifc_dp
  import pifc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pifc_in_t  in_data,
  input  pifc_cmd_t cmd,
  output pifc_sts_t sts,
  output logic      out_valid,
  output pifc_out_t out_data
);

`include "padded_integer_field_formatter_core_macros.svh"

  logic              func_r, func_nxt;
  logic              neg_r, neg_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [SUM_W-1:0]  wid_r, wid_nxt;
  logic [PREC_W-1:0] prec_r, prec_nxt;
  logic [SUM_W-1:0]  b1_r, b1_nxt, b2_r, b2_nxt, b3_r, b3_nxt;
  logic [SUM_W-1:0]  tot_r, tot_nxt, lastpos_r, lastpos_nxt;
  logic [SUM_W-1:0]  k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  pifc_out_t         out_r, out_nxt;

  logic [DD_W-1:0]       dd_v;
  logic [BCD_W-1:0]      hex_vec;
  logic [3:0]            dig [DIG_SLOTS];
  logic [SUM_W-1:0]      nd, mx, zeros, body, spaces, tot, emit_tot, kp1, idx;
  logic                  is_last;
  logic                  sign_bit;
  logic [VALUE_BITS-1:0] v_abs;

  // four double-dabble bits per cycle
  always_comb begin
    dd_v = {bcd_r, mag_r};
    for (int s = 0; s < 4; s++) begin
      dd_v = dd_step(dd_v);
    end
  end

  // digit view: BCD for decimal, nibbles for hex
  assign hex_vec = BCD_W'(mag_r);
  always_comb begin
    for (int i = 0; i < DIG_SLOTS; i++) begin
      if (i < DEC_DIGITS) begin
        dig[i] = (func_r == FUNC_HEX) ? hex_vec[4*i +: 4] : bcd_r[4*i +: 4];
      end else begin
        dig[i] = 4'd0;
      end
    end
  end

  // field layout
  always_comb begin
    nd = SUM_W'(1);
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        nd = SUM_W'(i + 1);
      end
    end
    mx       = (SUM_W'(prec_r) > nd) ? SUM_W'(prec_r) : nd;
    zeros    = mx - nd;
    body     = mx + SUM_W'(neg_r);
    spaces   = (wid_r > body) ? (wid_r - body) : '0;
    tot      = spaces + body;
    emit_tot = (tot > SUM_W'(MAX_WIDTH)) ? SUM_W'(MAX_WIDTH) : tot;
  end

  assign sign_bit = (in_data.func == FUNC_DEC) && in_data.value[VALUE_BITS-1];
  assign v_abs    = sign_bit ? (~in_data.value + 1'b1) : in_data.value;

  assign is_last = (k_r == lastpos_r);
  assign kp1     = k_r + SUM_W'(1);
  assign idx     = tot_r - kp1;  // digit position counted from the right

  always_comb begin
    func_nxt      = func_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    wid_nxt       = wid_r;
    prec_nxt      = prec_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    b3_nxt        = b3_r;
    tot_nxt       = tot_r;
    lastpos_nxt   = lastpos_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (cmd.load) begin
      func_nxt = in_data.func;
      neg_nxt  = sign_bit;
      mag_nxt  = MAG_W'(v_abs);
      bcd_nxt  = '0;
      wid_nxt  = (in_data.field_width > FWIDTH_W'(MAX_WIDTH)) ?
                 SUM_W'(MAX_WIDTH) : SUM_W'(in_data.field_width);
      prec_nxt = in_data.precision;
    end

    if (cmd.conv && (func_r == FUNC_DEC)) begin
      {bcd_nxt, mag_nxt} = dd_v;
    end

    if (cmd.size) begin
      b1_nxt      = spaces;
      b2_nxt      = spaces + SUM_W'(neg_r);
      b3_nxt      = spaces + SUM_W'(neg_r) + zeros;
      tot_nxt     = tot;
      lastpos_nxt = emit_tot - SUM_W'(1);
      k_nxt       = '0;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      k_nxt         = kp1;
      if (k_r < b1_r) begin
        out_nxt.character = CH_SPACE;
      end else if (k_r < b2_r) begin
        out_nxt.character = CH_MINUS;
      end else if (k_r < b3_r) begin
        out_nxt.character = CH_ZERO;
      end else begin
        out_nxt.character = digit_char(dig[idx[DIG_IDX_W-1:0]]);
      end
      out_nxt.last       = is_last;
      out_nxt.char_count = is_last ? kp1[COUNT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    bcd_r     <= bcd_nxt;
    wid_r     <= wid_nxt;
    prec_r    <= prec_nxt;
    b1_r      <= b1_nxt;
    b2_r      <= b2_nxt;
    b3_r      <= b3_nxt;
    tot_r     <= tot_nxt;
    lastpos_r <= lastpos_nxt;
    k_r       <= k_nxt;
    out_r     <= out_nxt;
  end

  assign sts.is_hex    = (func_r == FUNC_HEX);
  assign sts.emit_last = is_last;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  `PIFC_ASSERT_IMPLY(a_count_mid, clk, rst_n, out_valid_r && !out_r.last, out_r.char_count == '0)
  `PIFC_ASSERT_IMPLY(a_count_last, clk, rst_n, out_valid_r && out_r.last, out_r.char_count != '0)
  `PIFC_ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_valid_r && out_r.last, !out_valid_r)
  `PIFC_ASSERT_NEXT(a_no_gap_inside, clk, rst_n, out_valid_r && !out_r.last, out_valid_r)

endmodule

@@ hdl/padded_integer_field_formatter_core.sv @@
// ----------------------------------------------------------------------------
// padded_integer_field_formatter_core
// Formats one integer into a padded text field, one ASCII word per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and pulse start while busy is low; the word is taken on
//   that edge. func selects signed decimal or unsigned lowercase hex.
//   Output words appear on out_data with out_valid high for one cycle each,
//   in field order: spaces, '-', precision zeros, digits. The final word
//   has last set and char_count holding the number of words emitted.
// Sequence:
//   Decimal: load, conversion (double dabble, four bits per cycle),
//   sizing, then one output word per character of the field (at most
//   64). Hex passes through the conversion state without converting.
//   A new item can be taken in the cycle the last word is shown.
// Reset: rst_n low returns the sequencer to idle and drops out_valid.
// The receiver cannot stall; out_valid words must be taken as they come.
// ----------------------------------------------------------------------------
module padded_integer_field_formatter_core
  import pifc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  pifc_in_t  in_data,
  output logic      out_valid,
  output pifc_out_t out_data
);

  pifc_cmd_t cmd;
  pifc_sts_t sts;

  pifc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  pifc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
